// File: rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types and constants for the integer matrix multiplier: controller
// states, configuration register indexes and the command and status groups
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package imm_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int ELEM_W      = 32;
    localparam int OUT_IDX_W   = 3;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_W       = 4;
    localparam int CFG_INDEX_W = 2;

    // Reset value of every dimension register.
    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    // Configuration register indexes.
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_ROWS_A    = 2'd0;
    localparam cfg_index_t CFG_INNER_DIM = 2'd1;
    localparam cfg_index_t CFG_COLS_B    = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WAIT,
        ST_ISSUE
    } state_t;

    // Tag that travels with each read through the multiply-accumulate pipeline.
    typedef struct packed {
        logic                 first;
        logic                 last;
        logic                 final_res;
        logic [OUT_IDX_W-1:0] out_row;
        logic [OUT_IDX_W-1:0] out_col;
    } pipe_tag_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      wr_a;
        logic      wr_b;
        logic      issue;
        pipe_tag_t tag;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

// File: rtl/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Controller: holds the dimension registers, counts the incoming elements of
// A and B into their stores, then sequences one dot product at a time through
// the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module imm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  imm_pkg::cfg_index_t           cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  imm_pkg::sts_t                 sts,
    output imm_pkg::cmd_t                 cmd,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
    output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b
);
    import imm_pkg::*;

    localparam int AW    = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0]   ld_row_reg, ld_row_next;
    logic [IDX_W-1:0]   ld_col_reg, ld_col_next;
    logic               phase_b_reg, phase_b_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [DIM_W-1:0]   r_dim, k_dim, c_dim;
    logic               cfg_hit;
    logic               i_end, j_end, t_end;
    logic               ld_col_end_a, ld_col_end_b, ld_row_end_a, ld_row_end_b;

    // Clamp a register value into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W:0] wide;
        logic [CFG_W:0] lim;
        wide = {1'b0, v};
        lim  = (CFG_W + 1)'(MAX_DIM);
        if (v == '0)
            return DIM_W'(1);
        else if (wide > lim)
            return DIM_W'(MAX_DIM);
        else
            return DIM_W'(v);
    endfunction

    assign r_dim = clamp_dim(rows_a_reg);
    assign k_dim = clamp_dim(inner_dim_reg);
    assign c_dim = clamp_dim(cols_b_reg);

    // Last-index flags for the load and compute counters.
    assign ld_col_end_a = (DIM_W'(ld_col_reg) == k_dim - DIM_W'(1));
    assign ld_row_end_a = (DIM_W'(ld_row_reg) == r_dim - DIM_W'(1));
    assign ld_col_end_b = (DIM_W'(ld_col_reg) == c_dim - DIM_W'(1));
    assign ld_row_end_b = (DIM_W'(ld_row_reg) == k_dim - DIM_W'(1));
    assign i_end        = (DIM_W'(i_reg) == r_dim - DIM_W'(1));
    assign j_end        = (DIM_W'(j_reg) == c_dim - DIM_W'(1));
    assign t_end        = (DIM_W'(t_reg) == k_dim - DIM_W'(1));

    // Store addresses: row times MAX_DIM plus column.
    assign wr_addr   = AW'(AW'(ld_row_reg) * AW'(MAX_DIM) + AW'(ld_col_reg));
    assign rd_addr_a = AW'(AW'(i_reg) * AW'(MAX_DIM) + AW'(t_reg));
    assign rd_addr_b = AW'(AW'(t_reg) * AW'(MAX_DIM) + AW'(j_reg));

    assign s_axis_tready = (state_reg == ST_LOAD);

    // A write to any defined register restarts the load count.
    always_comb
    begin
        unique case (cfg_index)
            CFG_ROWS_A, CFG_INNER_DIM, CFG_COLS_B: cfg_hit = cfg_wr_en;
            default:                               cfg_hit = 1'b0;
        endcase
    end

    // Dimension registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            cols_b_reg    <= DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                CFG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                CFG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            ld_row_reg  <= '0;
            ld_col_reg  <= '0;
            phase_b_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            t_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ld_row_reg  <= ld_row_next;
            ld_col_reg  <= ld_col_next;
            phase_b_reg <= phase_b_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            t_reg       <= t_next;
        end
    end

    // Next state, counters and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        ld_row_next  = ld_row_reg;
        ld_col_next  = ld_col_reg;
        phase_b_next = phase_b_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        t_next       = t_reg;
        cmd          = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (s_axis_tvalid)
                begin
                    if (!phase_b_reg)
                    begin
                        cmd.wr_a = 1'b1;
                        if (ld_col_end_a)
                        begin
                            ld_col_next = '0;
                            if (ld_row_end_a)
                            begin
                                ld_row_next  = '0;
                                phase_b_next = 1'b1;
                            end
                            else
                            begin
                                ld_row_next = ld_row_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        cmd.wr_b = 1'b1;
                        if (ld_col_end_b)
                        begin
                            ld_col_next = '0;
                            if (ld_row_end_b)
                            begin
                                ld_row_next  = '0;
                                phase_b_next = 1'b0;
                                i_next       = '0;
                                j_next       = '0;
                                t_next       = '0;
                                state_next   = ST_WAIT;
                            end
                            else
                            begin
                                ld_row_next = ld_row_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            ld_col_next = ld_col_reg + IDX_W'(1);
                        end
                    end
                end
            end

            // Start a dot product once the pipeline is empty and the output
            // register will be free for its result.
            ST_WAIT:
            begin
                if (!sts.pipe_busy && sts.out_free)
                    state_next = ST_ISSUE;
            end

            ST_ISSUE:
            begin
                cmd.issue         = 1'b1;
                cmd.tag.first     = (t_reg == '0);
                cmd.tag.last      = t_end;
                cmd.tag.final_res = i_end && j_end;
                cmd.tag.out_row   = OUT_IDX_W'(i_reg);
                cmd.tag.out_col   = OUT_IDX_W'(j_reg);
                if (t_end)
                begin
                    t_next = '0;
                    if (j_end)
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            i_next     = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_WAIT;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_WAIT;
                    end
                end
                else
                begin
                    t_next = t_reg + IDX_W'(1);
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_hit)
        begin
            ld_row_next  = '0;
            ld_col_next  = '0;
            phase_b_next = 1'b0;
        end
    end

endmodule

// File: rtl/imm_datapath.sv
// ----------------------------------------------------------------------------
// imm_datapath
// Datapath: the A and B element stores, a registered read, one multiplier,
// the accumulator and the output register of the result stream.
// ----------------------------------------------------------------------------
module imm_datapath #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  imm_pkg::cmd_t                     cmd,
    output imm_pkg::sts_t                     sts,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_a,
    input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] rd_addr_b,
    input  logic [imm_pkg::ELEM_W-1:0]        s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [imm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast
);
    import imm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_WIDTH-1:0]   mem_a [DEPTH];
    logic [DATA_WIDTH-1:0]   mem_b [DEPTH];
    logic [DATA_WIDTH-1:0]   rd_a_reg, rd_b_reg;
    logic [DATA_WIDTH-1:0]   prod_reg;
    logic [DATA_WIDTH-1:0]   acc_reg;
    logic [DATA_WIDTH-1:0]   acc_next;
    logic [2*DATA_WIDTH-1:0] mult_full;
    logic                    v1_reg, v2_reg;
    pipe_tag_t               tag1_reg, tag2_reg;
    logic                    out_valid_reg;
    logic [ELEM_W-1:0]       out_product_reg;
    pipe_tag_t               out_tag_reg;
    logic                    land;

    // Element stores, written while loading and read while computing.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            mem_a[wr_addr] <= s_axis_tdata[DATA_WIDTH-1:0];
        if (cmd.issue)
            rd_a_reg <= mem_a[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            mem_b[wr_addr] <= s_axis_tdata[DATA_WIDTH-1:0];
        if (cmd.issue)
            rd_b_reg <= mem_b[rd_addr_b];
    end

    // The low DATA_WIDTH bits of the product do not depend on signedness.
    assign mult_full = {{DATA_WIDTH{1'b0}}, rd_a_reg} * {{DATA_WIDTH{1'b0}}, rd_b_reg};
    assign acc_next  = (tag2_reg.first ? '0 : acc_reg) + prod_reg;
    assign land      = v2_reg && tag2_reg.last;

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (land)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Multiply, accumulate and capture the finished dot product.
    always_ff @(posedge clk)
    begin
        tag1_reg <= cmd.tag;
        if (v1_reg)
        begin
            prod_reg <= mult_full[DATA_WIDTH-1:0];
            tag2_reg <= tag1_reg;
        end
        if (v2_reg)
            acc_reg <= acc_next;
        if (land)
        begin
            out_product_reg <= ELEM_W'(signed'(acc_next));
            out_tag_reg     <= tag2_reg;
        end
    end

    assign sts.pipe_busy = v1_reg || v2_reg;
    assign sts.out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_tag_reg.out_col, out_tag_reg.out_row, out_product_reg};
    assign m_axis_tlast  = out_tag_reg.final_res;

endmodule

// File: rtl/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Integer matrix multiplier. Elements of A (rows_a by inner_dim) and then of
// B (inner_dim by cols_b) arrive row-major on the input stream, one request
// per element. After the last element of B the block sends every element of
// A times B in row-major order on the output stream, each with its row and
// column index; tlast marks the last element of the product. Dot products
// wrap to DATA_WIDTH bits and are sign-extended to 32 bits.
// The configuration port writes the three dimensions (0 is taken as 1, and a
// value above MAX_DIM as MAX_DIM); a write to any of them restarts the element
// count. Write configuration only while the block is idle.
// Each product element is computed on the single shared multiply-accumulate
// unit: one read per cycle from each store, then a wait while the read and
// multiply stages empty before the next dot product is started.
// The input is not ready while the product is being computed. If the output
// is stalled the next dot product waits until the result register is free;
// nothing is lost. Reset sets every dimension to 8 and clears the element
// count; store contents are undefined.
// ----------------------------------------------------------------------------
module integer_matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  imm_pkg::cfg_index_t             cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]       cfg_wdata,
    // Input element stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [imm_pkg::ELEM_W-1:0]      s_axis_tdata,  // [31:0] element
    // Product stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [imm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] product,
                                                           // [34:32] out_row,
                                                           // [37:35] out_col,
                                                           // [39:38] zero
    output logic                            m_axis_tlast   // final_res
);
    import imm_pkg::*;

    localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    cmd_t          cmd;
    sts_t          sts;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;

    // Sequencer for loading and dot products.
    imm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b)
    );

    // Stores, multiply-accumulate unit and output register.
    imm_datapath #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .wr_addr       (wr_addr),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: bench/integer_matrix_multiply_checker.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_checker
// Watches the configuration port and both streams of the matrix multiplier.
// It keeps its own copy of the dimension registers, the element count and
// both matrix stores, and works out every product element when the last
// element of B is accepted. Each accepted product request is compared field
// by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  imm_pkg::cfg_index_t             cfg_index,
    input  logic [imm_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [imm_pkg::ELEM_W-1:0]      s_axis_tdata,  // [31:0] element
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [imm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] product,
                                                           // [34:32] out_row,
                                                           // [37:35] out_col,
                                                           // [39:38] zero
    input  logic                            m_axis_tlast,  // final_res
    output int                              mismatch_count,
    output int                              products_pending
);
    import imm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM       = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [ELEM_W-1:0]    product;
        logic [OUT_IDX_W-1:0] out_row;
        logic [OUT_IDX_W-1:0] out_col;
        logic                 final_res;
    } product_t;

    logic [CFG_W-1:0]  rows_a_q;
    logic [CFG_W-1:0]  inner_dim_q;
    logic [CFG_W-1:0]  cols_b_q;
    logic [ELEM_W-1:0] matrix_a [0:MAX_DIM*MAX_DIM-1];
    logic [ELEM_W-1:0] matrix_b [0:MAX_DIM*MAX_DIM-1];
    int                elements_loaded;
    int                failures;
    product_t          expected_products[$];

    // A dimension of zero behaves as one; anything above the store size is capped.
    function automatic int effective_dim(input logic [CFG_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > MAX_DIM)
            return MAX_DIM;
        return int'(value);
    endfunction

    // Any write to a known register restarts the element count.
    function automatic void write_dimension(input cfg_index_t index,
                                            input logic [CFG_W-1:0] value);
        case (index)
            CFG_ROWS_A:
            begin
                rows_a_q        = value;
                elements_loaded = 0;
            end
            CFG_INNER_DIM:
            begin
                inner_dim_q     = value;
                elements_loaded = 0;
            end
            CFG_COLS_B:
            begin
                cols_b_q        = value;
                elements_loaded = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Store one element and, once B is complete, queue the whole product.
    function automatic void load_element(input logic [ELEM_W-1:0] element);
        int                rows;
        int                inner;
        int                cols;
        int                count_a;
        int                count_b;
        int                offset;
        logic [ELEM_W-1:0] acc;
        product_t          entry;
        rows    = effective_dim(rows_a_q);
        inner   = effective_dim(inner_dim_q);
        cols    = effective_dim(cols_b_q);
        count_a = rows * inner;
        count_b = inner * cols;
        if (elements_loaded >= count_a + count_b)
            elements_loaded = 0;
        if (elements_loaded < count_a)
        begin
            matrix_a[(elements_loaded / inner) * MAX_DIM + elements_loaded % inner] = element;
        end
        else
        begin
            offset = elements_loaded - count_a;
            matrix_b[(offset / cols) * MAX_DIM + offset % cols] = element;
        end
        elements_loaded++;
        if (elements_loaded == count_a + count_b)
        begin
            for (int i = 0; i < rows; i++)
            begin
                for (int j = 0; j < cols; j++)
                begin
                    // The low 32 bits of each product are the same signed or unsigned.
                    acc = '0;
                    for (int t = 0; t < inner; t++)
                        acc = acc + matrix_a[i * MAX_DIM + t] * matrix_b[t * MAX_DIM + j];
                    entry.product   = acc;
                    entry.out_row   = OUT_IDX_W'(i);
                    entry.out_col   = OUT_IDX_W'(j);
                    entry.final_res = (i == rows - 1) && (j == cols - 1);
                    expected_products.push_back(entry);
                end
            end
            elements_loaded = 0;
        end
    endfunction

    // Predict on accepted requests and compare each accepted product.
    always @(posedge clk or negedge rst_n)
    begin
        product_t want;
        if (!rst_n)
        begin
            rows_a_q        = DIM_RESET;
            inner_dim_q     = DIM_RESET;
            cols_b_q        = DIM_RESET;
            elements_loaded = 0;
            failures        = 0;
            expected_products.delete();
            mismatch_count   <= 0;
            products_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                write_dimension(cfg_index, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready)
                load_element(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_products.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t ns: unexpected product %0d row %0d col %0d last %0b",
                                 $realtime, $signed(m_axis_tdata[31:0]),
                                 m_axis_tdata[34:32], m_axis_tdata[37:35], m_axis_tlast);
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (m_axis_tdata[31:0] !== want.product ||
                        m_axis_tdata[34:32] !== want.out_row ||
                        m_axis_tdata[37:35] !== want.out_col ||
                        m_axis_tlast !== want.final_res)
                    begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display({"%0t ns: expected product %0d row %0d col %0d last %0b,",
                                      " got product %0d row %0d col %0d last %0b"},
                                     $realtime, $signed(want.product), want.out_row,
                                     want.out_col, want.final_res,
                                     $signed(m_axis_tdata[31:0]), m_axis_tdata[34:32],
                                     m_axis_tdata[37:35], m_axis_tlast);
                    end
                end
            end
            mismatch_count   <= failures;
            products_pending <= expected_products.size();
        end
    end

endmodule

// File: bench/integer_matrix_multiply_tb.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_tb
// Drives the matrix multiplier with element streams for a series of matrix
// shapes: a directed opening covers the extreme element values, clamped
// dimensions, an ignored register index, a restart part way through a load
// and one run at full size, then random shapes with random contents follow,
// including some runs cut short. The sender works in bursts and the
// receiver stalls on patterns of its own; the checker beside the block
// predicts and compares every product element.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_tb;
    import imm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SETTLE_CYCLES = 16;
    localparam int         ITEM_TARGET   = 270;
    localparam cfg_index_t CFG_UNUSED    = 2'd3;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_pattern_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     cfg_wr_en     = 1'b0;
    cfg_index_t               cfg_index     = CFG_ROWS_A;
    logic [CFG_W-1:0]         cfg_wdata     = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [ELEM_W-1:0]        s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     m_axis_tlast;
    int                       mismatch_count;
    int                       products_pending;

    int                       elements_sent = 0;
    int                       burst_left    = 0;
    rx_pattern_t              rx_pattern;
    int                       rx_left;

    integer_matrix_multiply u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    integer_matrix_multiply_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_axis_tvalid    (s_axis_tvalid),
        .s_axis_tready    (s_axis_tready),
        .s_axis_tdata     (s_axis_tdata),
        .m_axis_tvalid    (m_axis_tvalid),
        .m_axis_tready    (m_axis_tready),
        .m_axis_tdata     (m_axis_tdata),
        .m_axis_tlast     (m_axis_tlast),
        .mismatch_count   (mismatch_count),
        .products_pending (products_pending)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // The receiver picks a new stall pattern whenever its countdown runs out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_pattern    <= RX_STEADY;
            rx_left       <= 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
                rx_left    <= $urandom_range(4, 40);
            end
            else
            begin
                rx_left <= rx_left - 1;
            end
            case (rx_pattern)
                RX_STEADY: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= $urandom_range(0, 1);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // Write one register, then drop the write enable and leave the port quiet.
    task automatic write_register(input cfg_index_t index, input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_dimensions(input logic [CFG_W-1:0] rows,
                                  input logic [CFG_W-1:0] inner,
                                  input logic [CFG_W-1:0] cols);
        write_register(CFG_ROWS_A, rows);
        write_register(CFG_INNER_DIM, inner);
        write_register(CFG_COLS_B, cols);
    endtask

    // Send one element request; a new burst may open with a random gap.
    task automatic push_element(input logic [ELEM_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        elements_sent++;
    endtask

    // Full-range values, with the extremes and small values mixed in.
    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return 32'hffff_ffff;
            4, 5:    return ELEM_W'($urandom_range(0, 200) - 100);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_random(input int count);
        for (int n = 0; n < count; n++)
            push_element(random_element());
    endtask

    // Stop sending and wait until every product has come and the block is quiet.
    task automatic drain_products();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (products_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Small shapes are favoured so that most runs stay short.
    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return 8;
            1, 2:    return $urandom_range(4, 7);
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    // Sometimes reach a dimension through its clamped register value.
    function automatic logic [CFG_W-1:0] register_value(input int dim);
        if (dim == 1 && $urandom_range(0, 1) == 1)
            return '0;
        if (dim == 8 && $urandom_range(0, 1) == 1)
            return CFG_W'($urandom_range(9, 15));
        return CFG_W'(dim);
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int rows;
        int inner;
        int cols;
        int run_length;
        int runs;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element products at the extremes of the element range.
        set_dimensions(4'd1, 4'd1, 4'd1);
        push_element(32'h8000_0000);
        push_element(32'h8000_0000);
        push_element(32'h7fff_ffff);
        push_element(32'h7fff_ffff);
        push_element(32'hffff_ffff);
        push_element(32'h8000_0000);
        push_element(32'h0000_0000);
        push_element(32'h1234_5678);
        drain_products();

        // An unused register index between runs, then clamped dimensions.
        write_register(CFG_UNUSED, 4'hf);
        set_dimensions(4'd15, 4'd0, 4'd0);
        push_random(9);
        drain_products();

        // A register write part way through loading restarts the run.
        set_dimensions(4'd1, 4'd2, 4'd1);
        push_random(3);
        drain_products();
        write_register(CFG_INNER_DIM, 4'd2);
        push_random(4);
        drain_products();

        // One run at full size.
        set_dimensions(4'd8, 4'd8, 4'd8);
        push_random(128);
        drain_products();

        // Random shapes, one to three runs each, now and then one cut short.
        while (elements_sent < ITEM_TARGET)
        begin
            rows       = pick_dim();
            inner      = pick_dim();
            cols       = pick_dim();
            run_length = rows * inner + inner * cols;
            set_dimensions(register_value(rows), register_value(inner), register_value(cols));
            runs = $urandom_range(1, 3);
            for (int n = 0; n < runs; n++)
            begin
                push_random(run_length);
                if ($urandom_range(0, 3) == 0)
                    drain_products();
            end
            if ($urandom_range(0, 4) == 0)
                push_random($urandom_range(1, run_length - 1));
            drain_products();
        end

        drain_products();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && products_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
